/* rtl/shhm_pkg.sv */
package shhm_pkg;

  // field widths
  localparam int DIR_W    = 16;
  localparam int SPEED_W  = 8;
  localparam int HEAD_W   = 16;
  localparam int GAIN_W   = 16;
  localparam int LIMIT_W  = 10;
  localparam int SECTOR_W = 3;

  // internal arithmetic widths
  localparam int REF_W   = HEAD_W + 1;            // latched heading reference
  localparam int ERR_W   = HEAD_W + 2;            // heading error
  localparam int SUM_W   = 32;                    // saturating error sum
  localparam int DER_W   = ERR_W + 1;             // error difference
  localparam int PP_W    = GAIN_W + 1 + ERR_W;    // proportional product
  localparam int PI_W    = GAIN_W + 1 + SUM_W;    // integral product
  localparam int PD_W    = GAIN_W + 1 + DER_W;    // derivative product
  localparam int ACC_W   = PI_W + 2;              // sum of the three terms
  localparam int FRAC_W  = 8;                     // Q8.8 fraction bits
  localparam int CORR_W  = LIMIT_W + 1;           // signed correction
  localparam int MIX_W   = CORR_W + 1;            // base speed plus correction
  localparam int ANGLE_W = 12;                    // direction modulo a full turn
  localparam int WRAP_W  = DIR_W + 1;

  // angles in tenths of a degree
  localparam int FULL_TURN    = 3600;
  localparam int DIR_OFFSET   = 36000;            // whole turns, makes any direction positive
  localparam int MOD_STEPS    = 5;                // 3600 << 4 covers the offset range
  localparam int SECTOR_WRAP  = 3375;
  localparam int SECTOR_EDGE1 = 225;
  localparam int SECTOR_EDGE2 = 675;
  localparam int SECTOR_EDGE3 = 1125;
  localparam int SECTOR_EDGE4 = 1575;
  localparam int SECTOR_EDGE5 = 2025;
  localparam int SECTOR_EDGE6 = 2475;
  localparam int SECTOR_EDGE7 = 2925;

  // ramp profile
  localparam logic [SPEED_W-1:0] RAMP_KNEE      = SPEED_W'(50);
  localparam logic [SPEED_W-1:0] RAMP_STEP_SLOW = SPEED_W'(2);
  localparam logic [SPEED_W-1:0] RAMP_STEP_FAST = SPEED_W'(3);
  localparam logic [SPEED_W-1:0] RAMP_STEP_DOWN = SPEED_W'(3);

  // register reset values
  localparam logic [GAIN_W-1:0]  GAIN_P_RST  = GAIN_W'(154);
  localparam logic [GAIN_W-1:0]  GAIN_I_RST  = GAIN_W'(0);
  localparam logic [GAIN_W-1:0]  GAIN_D_RST  = GAIN_W'(102);
  localparam logic [LIMIT_W-1:0] LIMIT_RST   = LIMIT_W'(250);
  localparam logic [SPEED_W-1:0] FLOOR_RST   = SPEED_W'(3);
  localparam logic [SPEED_W-1:0] CEILING_RST = SPEED_W'(254);

  // register map, word index on the bus
  localparam int ADDR_W = 5;
  typedef enum logic [2:0] {
    REG_GAIN_P        = 3'd0,
    REG_GAIN_I        = 3'd1,
    REG_GAIN_D        = 3'd2,
    REG_CORR_LIMIT    = 3'd3,
    REG_WHEEL_FLOOR   = 3'd4,
    REG_WHEEL_CEILING = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [DIR_W-1:0]  direction;
    logic [SPEED_W-1:0]       speed_goal;
    logic signed [HEAD_W-1:0] imu_heading;
    logic                     rearm;
  } in_item_t;

  typedef struct packed {
    logic [SPEED_W-1:0]       wheel_a_speed;
    logic [SPEED_W-1:0]       wheel_b_speed;
    logic [SPEED_W-1:0]       wheel_c_speed;
    logic [SPEED_W-1:0]       wheel_d_speed;
    logic signed [DIR_W-1:0]  steer_angle;
    logic [SECTOR_W-1:0]      sector;
    logic [SPEED_W-1:0]       ramped_speed;
  } out_item_t;

  // load strobes for the pid pipeline
  typedef struct packed {
    logic load_prod;
    logic load_acc;
  } pid_ctl_t;

  // how the correction enters one wheel
  typedef enum logic [1:0] {
    SIGN_ZERO  = 2'b00,
    SIGN_PLUS  = 2'b01,
    SIGN_MINUS = 2'b10
  } sign_t;

  localparam int WHEELS = 4;

  // per octant, wheels at 0h, 3h, 6h, 9h
  localparam sign_t SIGN_TABLE [8][WHEELS] = '{
    '{SIGN_PLUS,  SIGN_PLUS,  SIGN_MINUS, SIGN_MINUS},
    '{SIGN_ZERO,  SIGN_PLUS,  SIGN_ZERO,  SIGN_MINUS},
    '{SIGN_MINUS, SIGN_PLUS,  SIGN_PLUS,  SIGN_MINUS},
    '{SIGN_MINUS, SIGN_ZERO,  SIGN_PLUS,  SIGN_ZERO},
    '{SIGN_MINUS, SIGN_MINUS, SIGN_PLUS,  SIGN_PLUS},
    '{SIGN_ZERO,  SIGN_MINUS, SIGN_ZERO,  SIGN_PLUS},
    '{SIGN_PLUS,  SIGN_MINUS, SIGN_MINUS, SIGN_PLUS},
    '{SIGN_PLUS,  SIGN_ZERO,  SIGN_MINUS, SIGN_ZERO}
  };

  // direction modulo a full turn by restoring subtraction
  function automatic logic [ANGLE_W-1:0] wrap_angle(input logic signed [DIR_W-1:0] dir);
    logic [WRAP_W-1:0] x;
    logic [WRAP_W-1:0] step;
    x = WRAP_W'($signed({dir[DIR_W-1], dir}) + WRAP_W'(DIR_OFFSET));
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      step = WRAP_W'(FULL_TURN << k);
      if (x >= step) begin
        x = x - step;
      end
    end
    return x[ANGLE_W-1:0];
  endfunction

  // octant of a wrapped angle, octant 0 straddles zero
  function automatic logic [SECTOR_W-1:0] sector_of(input logic [ANGLE_W-1:0] a);
    logic [SECTOR_W-1:0] s;
    if (a > ANGLE_W'(SECTOR_WRAP) || a <= ANGLE_W'(SECTOR_EDGE1)) begin
      s = 3'd0;
    end else if (a <= ANGLE_W'(SECTOR_EDGE2)) begin
      s = 3'd1;
    end else if (a <= ANGLE_W'(SECTOR_EDGE3)) begin
      s = 3'd2;
    end else if (a <= ANGLE_W'(SECTOR_EDGE4)) begin
      s = 3'd3;
    end else if (a <= ANGLE_W'(SECTOR_EDGE5)) begin
      s = 3'd4;
    end else if (a <= ANGLE_W'(SECTOR_EDGE6)) begin
      s = 3'd5;
    end else if (a <= ANGLE_W'(SECTOR_EDGE7)) begin
      s = 3'd6;
    end else begin
      s = 3'd7;
    end
    return s;
  endfunction

endpackage

/* rtl/shhm_pid.sv */
module shhm_pid (
  input  logic                                  clk,
  input  shhm_pkg::pid_ctl_t                    ctl,
  input  logic [shhm_pkg::GAIN_W-1:0]           gain_p,
  input  logic [shhm_pkg::GAIN_W-1:0]           gain_i,
  input  logic [shhm_pkg::GAIN_W-1:0]           gain_d,
  input  logic [shhm_pkg::LIMIT_W-1:0]          correction_limit,
  input  logic signed [shhm_pkg::ERR_W-1:0]     err,
  input  logic signed [shhm_pkg::SUM_W-1:0]     err_sum,
  input  logic signed [shhm_pkg::DER_W-1:0]     deriv,
  output logic signed [shhm_pkg::CORR_W-1:0]    corr
);
  import shhm_pkg::*;

  logic signed [PP_W-1:0]  prod_p;
  logic signed [PI_W-1:0]  prod_i;
  logic signed [PD_W-1:0]  prod_d;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] lim;
  logic signed [ACC_W-1:0] neg_lim;
  logic signed [CORR_W-1:0] trunc;
  logic                     round_up;

  // three gain products, one multiplier each
  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      prod_p <= PP_W'($signed({1'b0, gain_p})) * PP_W'(err);
      prod_i <= PI_W'($signed({1'b0, gain_i})) * PI_W'(err_sum);
      prod_d <= PD_W'($signed({1'b0, gain_d})) * PD_W'(deriv);
    end
  end

  // exact q8.8 sum
  always_ff @(posedge clk) begin
    if (ctl.load_acc) begin
      acc <= ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);
    end
  end

  // clamp to the limit, else drop the fraction toward zero
  assign lim      = $signed({{(ACC_W - LIMIT_W - FRAC_W){1'b0}}, correction_limit, {FRAC_W{1'b0}}});
  assign neg_lim  = -lim;
  assign round_up = acc[ACC_W-1] && (acc[FRAC_W-1:0] != '0);
  assign trunc    = acc[FRAC_W+CORR_W-1:FRAC_W] + CORR_W'(round_up);

  always_comb begin
    if (acc > lim) begin
      corr = $signed({1'b0, correction_limit});
    end else if (acc < neg_lim) begin
      corr = -$signed({1'b0, correction_limit});
    end else begin
      corr = trunc;
    end
  end

endmodule

/* rtl/shhm_mix.sv */
module shhm_mix (
  input  logic [shhm_pkg::SPEED_W-1:0]        base_speed,
  input  logic [shhm_pkg::SECTOR_W-1:0]       sector,
  input  logic signed [shhm_pkg::CORR_W-1:0]  corr,
  input  logic [shhm_pkg::SPEED_W-1:0]        wheel_floor,
  input  logic [shhm_pkg::SPEED_W-1:0]        wheel_ceiling,
  output logic [shhm_pkg::SPEED_W-1:0]        wheel_speed [shhm_pkg::WHEELS]
);
  import shhm_pkg::*;

  logic signed [MIX_W-1:0] base;
  logic signed [MIX_W-1:0] ceil_s;
  logic signed [MIX_W-1:0] floor_s;
  logic signed [MIX_W-1:0] mixed [WHEELS];

  assign base    = $signed({{(MIX_W - SPEED_W){1'b0}}, base_speed});
  assign ceil_s  = $signed({{(MIX_W - SPEED_W){1'b0}}, wheel_ceiling});
  assign floor_s = $signed({{(MIX_W - SPEED_W){1'b0}}, wheel_floor});

  // add, subtract or skip the correction per wheel, then clamp, ceiling first
  always_comb begin
    for (int w = 0; w < WHEELS; w++) begin
      case (SIGN_TABLE[sector][w])
        SIGN_PLUS:  mixed[w] = base + MIX_W'(corr);
        SIGN_MINUS: mixed[w] = base - MIX_W'(corr);
        default:    mixed[w] = base;
      endcase
      if (mixed[w] >= ceil_s) begin
        wheel_speed[w] = wheel_ceiling;
      end else if (mixed[w] <= floor_s) begin
        wheel_speed[w] = wheel_floor;
      end else begin
        wheel_speed[w] = mixed[w][SPEED_W-1:0];
      end
    end
  end

endmodule

/* rtl/swerve_heading_hold_mixer_core.sv */
// Heading-hold mixer for a four-wheel swerve base, one item per control tick.
// Input channel in_valid / in_stall / in_item carries direction, target speed,
// IMU heading and the rearm flag; the output channel out_valid / out_stall /
// out_item carries the four clamped wheel speeds, steering angle, octant and
// ramped base speed. Gains, correction limit and wheel clamp sit on an APB
// port (word registers at 0x00..0x14, pready always high); the user must
// change them only while the block is idle, which the block does not enforce.
// An item accepted into the input register passes the state update, gain
// products and sum stages before the result register shows it on out_item.
// Throughput: one item per cycle unless stalled; ramp, heading latch and error
// sum are all updated in the single state stage, so back-to-back items see
// each other. The gain multipliers and the 51-bit sum set the stage split.
// Reset clears the pipeline, loads the register defaults, zeroes ramp, error
// sum and last error, and arms a heading capture for the first item.
// When the receiver stalls the result register holds and stages behind it
// fill in turn; in_stall rises only once every stage is occupied.
module swerve_heading_hold_mixer_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  shhm_pkg::in_item_t                   in_item,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output shhm_pkg::out_item_t                  out_item,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [shhm_pkg::ADDR_W-1:0]          paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import shhm_pkg::*;

  // configuration registers
  logic [GAIN_W-1:0]  gain_p;
  logic [GAIN_W-1:0]  gain_i;
  logic [GAIN_W-1:0]  gain_d;
  logic [LIMIT_W-1:0] correction_limit;
  logic [SPEED_W-1:0] wheel_floor;
  logic [SPEED_W-1:0] wheel_ceiling;
  logic               cfg_write;
  reg_idx_t           cfg_idx;

  // tick state
  logic [SPEED_W-1:0]      ramp_speed, ramp_speed_next;
  logic                    ramp_phase, ramp_phase_next;
  logic signed [REF_W-1:0] heading_ref, heading_ref_next;
  logic                    capture_pending;
  logic signed [SUM_W-1:0] error_sum, error_sum_next;
  logic signed [ERR_W-1:0] last_error;

  // pipeline
  logic v0, v1, v2, v3;
  logic rdy0, rdy1, rdy2, rdy3, rdy_out;
  logic adv1;
  in_item_t s0_item;

  logic signed [DIR_W-1:0] s1_dir, s2_dir, s3_dir;
  logic [SECTOR_W-1:0]     s1_sector, s2_sector, s3_sector;
  logic [SPEED_W-1:0]      s1_ramp, s2_ramp, s3_ramp;
  logic signed [ERR_W-1:0] s1_err;
  logic signed [SUM_W-1:0] s1_sum;
  logic signed [DER_W-1:0] s1_deriv;

  logic signed [ERR_W-1:0]   err;
  logic signed [SUM_W:0]     sum_wide;
  logic [SPEED_W:0]          ramp_up;
  logic [SECTOR_W-1:0]       sector;
  pid_ctl_t                  pid_ctl;
  logic signed [CORR_W-1:0]  corr;
  logic [SPEED_W-1:0]        wheel_speed [WHEELS];

  // apb register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p           <= GAIN_P_RST;
      gain_i           <= GAIN_I_RST;
      gain_d           <= GAIN_D_RST;
      correction_limit <= LIMIT_RST;
      wheel_floor      <= FLOOR_RST;
      wheel_ceiling    <= CEILING_RST;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_GAIN_P:        gain_p           <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:        gain_i           <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:        gain_d           <= pwdata[GAIN_W-1:0];
        REG_CORR_LIMIT:    correction_limit <= pwdata[LIMIT_W-1:0];
        REG_WHEEL_FLOOR:   wheel_floor      <= pwdata[SPEED_W-1:0];
        REG_WHEEL_CEILING: wheel_ceiling    <= pwdata[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_GAIN_P:        prdata = 32'(gain_p);
      REG_GAIN_I:        prdata = 32'(gain_i);
      REG_GAIN_D:        prdata = 32'(gain_d);
      REG_CORR_LIMIT:    prdata = 32'(correction_limit);
      REG_WHEEL_FLOOR:   prdata = 32'(wheel_floor);
      REG_WHEEL_CEILING: prdata = 32'(wheel_ceiling);
      default:           prdata = '0;
    endcase
  end

  // stage readiness, a stage moves on when the next one can take it
  assign rdy_out  = !out_valid || !out_stall;
  assign rdy3     = !v3 || rdy_out;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign rdy0     = !v0 || rdy1;
  assign in_stall = !rdy0;
  assign adv1     = v0 && rdy1;

  assign pid_ctl.load_prod = v1 && rdy2;
  assign pid_ctl.load_acc  = v2 && rdy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy0) begin
        v0 <= in_valid;
      end
      if (rdy1) begin
        v1 <= v0;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy_out) begin
        out_valid <= v3;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      s0_item <= in_item;
    end
  end

  // ramp toward target, a step on every other tick that needs one
  assign ramp_up = {1'b0, ramp_speed}
                 + {1'b0, (ramp_speed < RAMP_KNEE) ? RAMP_STEP_SLOW : RAMP_STEP_FAST};

  always_comb begin
    ramp_speed_next = ramp_speed;
    ramp_phase_next = ramp_phase;
    if (ramp_speed < s0_item.speed_goal) begin
      ramp_phase_next = !ramp_phase;
      if (!ramp_phase) begin
        if (ramp_up >= {1'b0, s0_item.speed_goal}) begin
          ramp_speed_next = s0_item.speed_goal;
        end else begin
          ramp_speed_next = ramp_up[SPEED_W-1:0];
        end
      end
    end else if (ramp_speed > s0_item.speed_goal) begin
      ramp_phase_next = !ramp_phase;
      if (!ramp_phase) begin
        if ({1'b0, ramp_speed} <= {1'b0, s0_item.speed_goal} + {1'b0, RAMP_STEP_DOWN}) begin
          ramp_speed_next = s0_item.speed_goal;
        end else begin
          ramp_speed_next = ramp_speed - RAMP_STEP_DOWN;
        end
      end
    end
  end

  // heading latch, error and saturating error sum
  always_comb begin
    if (s0_item.rearm || capture_pending) begin
      heading_ref_next = -REF_W'(s0_item.imu_heading);
    end else begin
      heading_ref_next = heading_ref;
    end
    err      = ERR_W'(heading_ref_next) + ERR_W'(s0_item.imu_heading);
    sum_wide = (SUM_W + 1)'(error_sum) + (SUM_W + 1)'(err);
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      error_sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                       : {1'b0, {(SUM_W - 1){1'b1}}};
    end else begin
      error_sum_next = sum_wide[SUM_W-1:0];
    end
  end

  assign sector = sector_of(wrap_angle(s0_item.direction));

  // state stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_speed      <= '0;
      ramp_phase      <= 1'b0;
      heading_ref     <= '0;
      capture_pending <= 1'b1;
      error_sum       <= '0;
      last_error      <= '0;
    end else if (adv1) begin
      ramp_speed      <= ramp_speed_next;
      ramp_phase      <= ramp_phase_next;
      heading_ref     <= heading_ref_next;
      capture_pending <= 1'b0;
      error_sum       <= error_sum_next;
      last_error      <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_dir    <= s0_item.direction;
      s1_sector <= sector;
      s1_ramp   <= ramp_speed_next;
      s1_err    <= err;
      s1_sum    <= error_sum_next;
      s1_deriv  <= DER_W'(err) - DER_W'(last_error);
    end
  end

  // sideband alongside the pid pipeline
  always_ff @(posedge clk) begin
    if (pid_ctl.load_prod) begin
      s2_dir    <= s1_dir;
      s2_sector <= s1_sector;
      s2_ramp   <= s1_ramp;
    end
    if (pid_ctl.load_acc) begin
      s3_dir    <= s2_dir;
      s3_sector <= s2_sector;
      s3_ramp   <= s2_ramp;
    end
  end

  shhm_pid u_pid (
    .clk              (clk),
    .ctl              (pid_ctl),
    .gain_p           (gain_p),
    .gain_i           (gain_i),
    .gain_d           (gain_d),
    .correction_limit (correction_limit),
    .err              (s1_err),
    .err_sum          (s1_sum),
    .deriv            (s1_deriv),
    .corr             (corr)
  );

  shhm_mix u_mix (
    .base_speed    (s3_ramp),
    .sector        (s3_sector),
    .corr          (corr),
    .wheel_floor   (wheel_floor),
    .wheel_ceiling (wheel_ceiling),
    .wheel_speed   (wheel_speed)
  );

  // result register
  always_ff @(posedge clk) begin
    if (v3 && rdy_out) begin
      out_item.wheel_a_speed <= wheel_speed[0];
      out_item.wheel_b_speed <= wheel_speed[1];
      out_item.wheel_c_speed <= wheel_speed[2];
      out_item.wheel_d_speed <= wheel_speed[3];
      out_item.steer_angle   <= s3_dir;
      out_item.sector        <= s3_sector;
      out_item.ramped_speed  <= s3_ramp;
    end
  end

  // the input side stalls only with every stage full and the output held
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v0 && v1 && v2 && v3 && out_valid && out_stall))
    else $error("input stalled with a free pipeline stage");

  // the first item through the state stage consumes the pending capture
  a_capture_once: assert property (@(posedge clk) disable iff (rst)
    adv1 |=> !capture_pending)
    else $error("heading capture still pending after an item");

  // delivered speeds of wheels a and c sit inside a well-formed clamp window
  a_wheel_window: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (wheel_floor <= wheel_ceiling)) |->
      (out_item.wheel_a_speed >= wheel_floor && out_item.wheel_a_speed <= wheel_ceiling &&
       out_item.wheel_c_speed >= wheel_floor && out_item.wheel_c_speed <= wheel_ceiling))
    else $error("wheel speed outside the clamp window");

endmodule
